>>> rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Widths, register indexes and reset values shared by the XTEA cipher engine.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int WORD_W    = 32;
    localparam int ROUND_W   = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [ROUND_W-1:0]   round_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam word_t DELTA = 32'h9E37_79B9;

    localparam cfg_idx_t CFG_KEY_ZERO  = 3'd0;
    localparam cfg_idx_t CFG_KEY_ONE   = 3'd1;
    localparam cfg_idx_t CFG_KEY_TWO   = 3'd2;
    localparam cfg_idx_t CFG_KEY_THREE = 3'd3;
    localparam cfg_idx_t CFG_ROUNDS    = 3'd4;

    localparam word_t  KEY_ZERO_RST  = 32'h99AB_129F;
    localparam word_t  KEY_ONE_RST   = 32'h4DE1_E6FA;
    localparam word_t  KEY_TWO_RST   = 32'hBBE8_B100;
    localparam word_t  KEY_THREE_RST = 32'hFA88_8EF3;
    localparam round_t ROUNDS_RST    = 7'd32;

endpackage

>>> rtl/xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// XTEA block cipher
// Enciphers or deciphers one 64-bit block under a 128-bit key with one shared
// half-round unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Direction
//  input     s_valid s_ready s_op s_block_low/high    in
//  result    m_valid m_ready m_result_low/high        out
//  config    cfg_valid cfg_ready cfg_index cfg_data   in
//
// A block goes from its transfer to its result register through ST_INIT,
// which sets the start sum, then ST_RUN, two half-round steps per round
// through the shared half-round adder chain, then ST_DONE, which loads
// the result register. A new block is taken only in ST_IDLE.
// Reset (synchronous, active low) restores the key and round count defaults.
// The next block is taken while a finished result waits for m_ready; a
// result stalled on m_ready holds the engine in its final state.
// ----------------------------------------------------------------------------
module xtea_block_cipher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  xtea_pkg::word_t     s_block_low,
    input  xtea_pkg::word_t     s_block_high,
    output logic                m_valid,
    input  logic                m_ready,
    output xtea_pkg::word_t     m_result_low,
    output xtea_pkg::word_t     m_result_high,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  xtea_pkg::cfg_idx_t  cfg_index,
    input  xtea_pkg::word_t     cfg_data
);
    import xtea_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    word_t      key0_reg, key1_reg, key2_reg, key3_reg;
    round_t     rounds_reg;
    logic       dec_reg, dec_next;
    logic       phase_reg, phase_next;
    round_t     left_reg, left_next;
    word_t      a_reg, a_next;
    word_t      b_reg, b_next;
    word_t      sum_reg, sum_next;
    logic       m_valid_reg, m_valid_next;
    word_t      res_lo_reg, res_lo_next;
    word_t      res_hi_reg, res_hi_next;

    logic       use_high;
    logic [1:0] key_sel;
    word_t      key_word;
    word_t      w_op;
    word_t      t_op;
    word_t      mix_w;
    word_t      f_val;
    word_t      half_res;
    word_t      dec_start;
    logic       out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_result_low  = res_lo_reg;
    assign m_result_high = res_hi_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg   <= KEY_ZERO_RST;
            key1_reg   <= KEY_ONE_RST;
            key2_reg   <= KEY_TWO_RST;
            key3_reg   <= KEY_THREE_RST;
            rounds_reg <= ROUNDS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KEY_ZERO:  key0_reg   <= cfg_data;
                CFG_KEY_ONE:   key1_reg   <= cfg_data;
                CFG_KEY_TWO:   key2_reg   <= cfg_data;
                CFG_KEY_THREE: key3_reg   <= cfg_data;
                CFG_ROUNDS:    rounds_reg <= cfg_data[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    // The half-round working on word b as its target also uses the upper key
    // index bits; this holds for both directions.
    assign use_high = phase_reg ^ dec_reg;
    assign key_sel  = use_high ? sum_reg[12:11] : sum_reg[1:0];
    assign w_op     = use_high ? a_reg : b_reg;
    assign t_op     = use_high ? b_reg : a_reg;

    always_comb begin
        unique case (key_sel)
            2'd0:    key_word = key0_reg;
            2'd1:    key_word = key1_reg;
            2'd2:    key_word = key2_reg;
            default: key_word = key3_reg;
        endcase
    end

    assign mix_w     = ((w_op << 4) ^ (w_op >> 5)) + w_op;
    assign f_val     = mix_w ^ (sum_reg + key_word);
    assign half_res  = dec_reg ? (t_op - f_val) : (t_op + f_val);
    assign dec_start = WORD_W'(DELTA * {{(WORD_W-ROUND_W){1'b0}}, left_reg});

    always_comb begin
        state_next   = state_reg;
        dec_next     = dec_reg;
        phase_next   = phase_reg;
        left_next    = left_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        res_lo_next  = res_lo_reg;
        res_hi_next  = res_hi_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dec_next   = s_op;
                    a_next     = s_block_low;
                    b_next     = s_block_high;
                    left_next  = rounds_reg;
                    phase_next = 1'b0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                sum_next   = dec_reg ? dec_start : '0;
                state_next = (left_reg == '0) ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                if (use_high) begin
                    b_next = half_res;
                end else begin
                    a_next = half_res;
                end
                if (!phase_reg) begin
                    sum_next = dec_reg ? (sum_reg - DELTA) : (sum_reg + DELTA);
                end else begin
                    left_next = left_reg - ROUND_W'(1);
                    if (left_reg == ROUND_W'(1)) begin
                        state_next = ST_DONE;
                    end
                end
                phase_next = !phase_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    res_lo_next  = a_reg;
                    res_hi_next  = b_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
            left_reg    <= '0;
            dec_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            dec_reg     <= dec_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        sum_reg    <= sum_next;
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
    end

    a_accept_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_INIT))
        else $error("Accepted block did not start the sequencer.");

    a_run_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (left_reg != '0))
        else $error("Round engine running with no rounds left.");

    a_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && phase_reg && left_reg == ROUND_W'(1))
        |=> (state_reg == ST_DONE))
        else $error("Last round did not finish the block.");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("Result appeared without a finished block.");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE))
        else $error("Finished block left while the result register was full.");

endmodule
